[rtl/ngl_pkg.sv]
// ----------------------------------------------------------------------------
// ngl_pkg: shared types and constants
// Payload structs and fixed widths for the normalized graph Laplacian block.
// ----------------------------------------------------------------------------
package ngl_pkg;

	localparam int MAX_SIZE_DEF = 64;
	localparam int SIZE_W       = 7;
	localparam int IDX_W        = 6;
	localparam int WEIGHT_W     = 16;
	localparam int DEG_W        = 22;
	localparam int FACTOR_W     = 18;
	localparam int VALUE_W      = 17;

	localparam logic [1:0] KIND_WRITE  = 2'd0;
	localparam logic [1:0] KIND_FINISH = 2'd1;
	localparam logic [1:0] KIND_READ   = 2'd2;
	localparam logic [1:0] KIND_UNUSED = 2'd3;

	typedef struct packed {
		logic [1:0]          kind;
		logic [IDX_W-1:0]    row;
		logic [IDX_W-1:0]    col;
		logic [WEIGHT_W-1:0] weight;
	} cmd_t;

	typedef struct packed {
		logic signed [VALUE_W-1:0] value;
		logic [IDX_W-1:0]          col_index;
		logic                      last;
		logic                      zero_degree;
	} res_t;

endpackage

[rtl/ngl_factor.sv]
// ----------------------------------------------------------------------------
// ngl_factor: inverse square root unit
// Computes floor(sqrt(2^45 / d)) saturated to 18 bits: a restoring divide,
// then a 23-step bit-pair square root.
// ----------------------------------------------------------------------------
module ngl_factor
	import ngl_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                go,
	input  logic [DEG_W-1:0]    degree,
	output logic                done,
	output logic [FACTOR_W-1:0] factor
);

	typedef enum logic [1:0] {S_IDLE, S_DIV, S_SQRT, S_DONE} st_t;

	st_t              st_q;
	logic [5:0]       cnt_q;
	logic [45:0]      quot_q;
	logic [DEG_W:0]   rem_q;
	logic [DEG_W-1:0] den_q;
	logic [45:0]      rad_q;
	logic [22:0]      sres_q;
	logic [47:0]      srem_q;
	logic [FACTOR_W-1:0] factor_q;

	logic [DEG_W:0]   rem_sh;
	logic [47:0]      srem_sh;
	logic [47:0]      trial;

	always_comb begin
		rem_sh  = {rem_q[DEG_W-1:0], (cnt_q == 6'd45)};
		srem_sh = {srem_q[45:0], rad_q[45:44]};
		trial   = {23'd0, sres_q, 2'b01};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			cnt_q <= '0;
		end else begin
			unique case (st_q)
				S_IDLE: if (go) begin
					den_q  <= degree;
					rem_q  <= '0;
					quot_q <= '0;
					cnt_q  <= 6'd45;
					st_q   <= S_DIV;
				end
				S_DIV: begin
					// one quotient bit a cycle; dividend is a single one at bit 45
					if (rem_sh >= {1'b0, den_q}) begin
						rem_q  <= rem_sh - {1'b0, den_q};
						quot_q <= {quot_q[44:0], 1'b1};
					end else begin
						rem_q  <= rem_sh;
						quot_q <= {quot_q[44:0], 1'b0};
					end
					if (cnt_q == 6'd0) begin
						st_q  <= S_SQRT;
						cnt_q <= 6'd22;
					end else begin
						cnt_q <= cnt_q - 6'd1;
					end
				end
				S_SQRT: begin
					if (srem_sh >= trial) begin
						srem_q <= srem_sh - trial;
						sres_q <= {sres_q[21:0], 1'b1};
					end else begin
						srem_q <= srem_sh;
						sres_q <= {sres_q[21:0], 1'b0};
					end
					rad_q <= {rad_q[43:0], 2'b00};
					if (cnt_q == 6'd0) st_q <= S_DONE;
					else cnt_q <= cnt_q - 6'd1;
				end
				S_DONE: st_q <= S_IDLE;
				default: st_q <= S_IDLE;
			endcase
			if (st_q == S_DIV && cnt_q == 6'd0) begin
				rad_q  <= (rem_sh >= {1'b0, den_q}) ? {quot_q[44:0], 1'b1}
				                                    : {quot_q[44:0], 1'b0};
				sres_q <= '0;
				srem_q <= '0;
			end
			if (st_q == S_SQRT && cnt_q == 6'd0) begin
				factor_q <= (srem_sh >= trial)
					? (sres_q[21:17] != 0 ? {FACTOR_W{1'b1}} : {sres_q[16:0], 1'b1})
					: (sres_q[21:17] != 0 ? {FACTOR_W{1'b1}} : {sres_q[16:0], 1'b0});
			end
		end
	end

	assign done   = (st_q == S_DONE);
	assign factor = factor_q;

endmodule

[rtl/normalized_graph_laplacian.sv]
// ----------------------------------------------------------------------------
// normalized_graph_laplacian: L = I - D^-1/2 W D^-1/2
// Command-driven store of an affinity matrix with per-row degrees.
// ----------------------------------------------------------------------------
// Commands enter on cmd when start is high and busy is low. A write beat
// reads the old weight and row degree in S_WRD, then writes both back in
// S_WWR; busy stays high until the write-back is done.
// A finish beat walks all rows: it fetches (S_FRD) and checks (S_FCHK) a
// degree, and when the degree is nonzero waits in S_FWAIT for the inverse
// square root unit (divide, root, done) before it moves to the next row.
// A read beat fetches the row factor, then streams n results on res, one per
// cycle with strobe high; each passes the read pipeline stages before res,
// last marks the final column; busy stays high through S_RROW and S_READ.
// The receiver cannot stall; results are simply presented for one cycle.
// cfg_valid/cfg_ready writes matrix_size; ready is high only while idle
// and no command is offered.
// After reset the block runs a clearing pass over both memories, one entry a
// cycle through 4^clog2(min(MAX_SIZE,64)) addresses (4096 by default), busy high.
// ----------------------------------------------------------------------------
module normalized_graph_laplacian
	import ngl_pkg::*;
#(
	parameter int MAX_SIZE = MAX_SIZE_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  cmd_t              cmd,
	output logic              busy,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [SIZE_W-1:0] cfg_data,
	output logic              strobe,
	output res_t              res
);

	localparam int LIMIT  = (MAX_SIZE < 64) ? MAX_SIZE : 64;
	localparam int LIM_W  = $clog2(LIMIT);
	localparam int ADDR_W = 2 * LIM_W;
	localparam int NDEPTH = 1 << LIM_W;
	localparam int DEPTH  = 1 << ADDR_W;

	typedef enum logic [3:0] {
		S_CLEAR, S_IDLE, S_WRD, S_WWR, S_FRD, S_FCHK, S_FWAIT, S_RROW, S_READ
	} st_t;

	typedef struct packed {
		logic [DEG_W-1:0]    deg;
		logic [FACTOR_W-1:0] fac;
	} node_t;

	logic [WEIGHT_W-1:0] wmem [DEPTH];
	node_t               nmem [NDEPTH];

	st_t                 st_q;
	logic [ADDR_W:0]     clr_q;
	logic [SIZE_W-1:0]   size_q;
	logic [IDX_W-1:0]    row_q, col_q, fin_q;
	logic [WEIGHT_W-1:0] wnew_q;
	logic [FACTOR_W-1:0] fr_q;
	logic [SIZE_W-1:0]   n_eff;

	// memory ports
	logic [ADDR_W-1:0]   w_addr;
	logic                w_we;
	logic [WEIGHT_W-1:0] w_wdata, w_rd_q;
	logic [LIM_W-1:0]    n_addr;
	logic                n_we;
	node_t               n_wdata, n_rd_q;
	logic [DEG_W-1:0]    deg_upd;

	// read pipeline
	logic                v_s1, v_s2;
	logic [IDX_W-1:0]    c_s1, c_s2;
	logic                l_s1, l_s2, z_s2, d_s2;
	logic [35:0]         ff_s2;
	logic [WEIGHT_W-1:0] w_s2;

	logic fgo, fdone;
	logic [FACTOR_W-1:0] fval;

	always_comb begin
		n_eff = (size_q == '0) ? SIZE_W'(1) : size_q;
		if (n_eff > SIZE_W'(LIMIT)) n_eff = SIZE_W'(LIMIT);
	end

	always_comb begin
		w_addr  = {row_q[LIM_W-1:0], col_q[LIM_W-1:0]};
		w_we    = 1'b0;
		w_wdata = wnew_q;
		n_addr  = row_q[LIM_W-1:0];
		n_we    = 1'b0;
		n_wdata = n_rd_q;
		deg_upd = n_rd_q.deg - DEG_W'(w_rd_q) + DEG_W'(wnew_q);
		unique case (st_q)
			S_CLEAR: begin
				w_addr  = clr_q[ADDR_W-1:0];
				w_we    = 1'b1;
				w_wdata = '0;
				n_addr  = clr_q[LIM_W-1:0];
				n_we    = 1'b1;
				n_wdata = '0;
			end
			S_WWR: begin
				// old weight and degree were read in the previous cycle
				w_we    = 1'b1;
				n_we    = 1'b1;
				n_wdata = {deg_upd, n_rd_q.fac};
			end
			S_FRD: n_addr = fin_q[LIM_W-1:0];
			S_FCHK: begin
				n_addr = fin_q[LIM_W-1:0];
				if (n_rd_q.deg == '0) begin
					n_we    = 1'b1;
					n_wdata = {n_rd_q.deg, {FACTOR_W{1'b0}}};
				end
			end
			S_FWAIT: begin
				// rereads the same entry, so n_rd_q holds its degree
				n_addr = fin_q[LIM_W-1:0];
				if (fdone) begin
					n_we    = 1'b1;
					n_wdata = {n_rd_q.deg, fval};
				end
			end
			S_READ: n_addr = col_q[LIM_W-1:0];
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (w_we) wmem[w_addr] <= w_wdata;
		w_rd_q <= wmem[w_addr];
	end

	always_ff @(posedge clk) begin
		if (n_we) nmem[n_addr] <= n_wdata;
		n_rd_q <= nmem[n_addr];
	end

	ngl_factor u_factor (
		.clk(clk), .arst_n(arst_n), .go(fgo),
		.degree(n_rd_q.deg), .done(fdone), .factor(fval)
	);

	assign fgo = (st_q == S_FCHK) && (n_rd_q.deg != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= S_CLEAR;
			clr_q  <= '0;
			size_q <= SIZE_W'(64);
			v_s1   <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) size_q <= cfg_data;
			v_s1 <= 1'b0;
			unique case (st_q)
				S_CLEAR: begin
					clr_q <= clr_q + (ADDR_W+1)'(1);
					if (clr_q == (ADDR_W+1)'(DEPTH - 1)) st_q <= S_IDLE;
				end
				S_IDLE: if (start) begin
					row_q  <= cmd.row;
					col_q  <= cmd.col;
					wnew_q <= cmd.weight;
					case (cmd.kind)
						KIND_WRITE:
							if ({1'b0, cmd.row} < n_eff && {1'b0, cmd.col} < n_eff)
								st_q <= S_WRD;
						KIND_FINISH: begin
							fin_q <= '0;
							st_q  <= S_FRD;
						end
						KIND_READ: if ({1'b0, cmd.row} < n_eff) begin
							col_q <= '0;
							st_q  <= S_RROW;
						end
						default: ;
					endcase
				end
				S_WRD: st_q <= S_WWR;
				S_WWR: st_q <= S_IDLE;
				S_FRD: st_q <= S_FCHK;
				S_FCHK: begin
					if (n_rd_q.deg == '0) begin
						if (fin_q == IDX_W'(LIMIT - 1)) st_q <= S_IDLE;
						else begin
							fin_q <= fin_q + IDX_W'(1);
							st_q  <= S_FRD;
						end
					end else begin
						st_q <= S_FWAIT;
					end
				end
				S_FWAIT: if (fdone) begin
					if (fin_q == IDX_W'(LIMIT - 1)) st_q <= S_IDLE;
					else begin
						fin_q <= fin_q + IDX_W'(1);
						st_q  <= S_FRD;
					end
				end
				S_RROW: st_q <= S_READ;
				S_READ: begin
					v_s1 <= 1'b1;
					c_s1 <= col_q;
					l_s1 <= ({1'b0, col_q} + SIZE_W'(1) == n_eff);
					// row factor arrives in the first column cycle
					if (col_q == '0) fr_q <= n_rd_q.fac;
					if ({1'b0, col_q} + SIZE_W'(1) == n_eff) st_q <= S_IDLE;
					else col_q <= col_q + IDX_W'(1);
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	// stage 2: factor product; stage 3: weight times product, round, saturate
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2   <= 1'b0;
			strobe <= 1'b0;
		end else begin
			v_s2   <= v_s1;
			strobe <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		ff_s2 <= 36'(fr_q) * 36'(n_rd_q.fac);
		w_s2  <= w_rd_q;
		c_s2  <= c_s1;
		l_s2  <= l_s1;
		z_s2  <= (fr_q == '0) || (n_rd_q.fac == '0);
		d_s2  <= (c_s1 == row_q);
	end

	logic [51:0] prod;
	logic [21:0] term;
	logic signed [23:0] vfull;
	always_comb begin
		prod  = 52'(ff_s2) * 52'(w_s2);
		term  = 22'((prod + 52'(1 << 29)) >> 30);
		vfull = (d_s2 ? 24'sd32768 : 24'sd0) - $signed({2'b00, term});
	end

	always_ff @(posedge clk) begin
		res.col_index   <= c_s2;
		res.last        <= l_s2;
		res.zero_degree <= z_s2;
		if (vfull < -24'sd65536) res.value <= -17'sd65536;
		else res.value <= vfull[VALUE_W-1:0];
	end

	assign busy      = (st_q != S_IDLE);
	assign cfg_ready = (st_q == S_IDLE) && !start;

endmodule
